@@ design/lbs_pkg.sv @@
// Shared types and constants for the longest bitonic subsequence core.
// Holds the input and result transfer structs and the engine status struct.
// No dependencies.
package lbs_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int SAMPLE_W    = 32;
  localparam int LENGTH_W    = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_item;
  } item_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] bitonic_length;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } lbs_stat_t;

endpackage

@@ design/lbs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Width and depth are parameters. No dependencies.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lbs_engine.sv @@
// Dynamic programming sequencer for the longest bitonic subsequence.
// Streams the value and length memories, writes rise and fall lengths back.
// Depends on lbs_pkg for constants and the status struct.
module lbs_engine #(
  parameter int MAX_LEN = lbs_pkg::MAX_LEN_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [CW-1:0]             n_in,
  output logic [AW-1:0]             rd_addr,
  input  logic [lbs_pkg::SAMPLE_W-1:0] val_rdata,
  input  logic [2*CW-1:0]           len_rdata,
  output logic                      len_we,
  output logic [AW-1:0]             len_waddr,
  output logic [2*CW-1:0]           len_wdata,
  output logic [CW:0]               best,
  output lbs_pkg::lbs_stat_t        stat
);
  import lbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HEAD  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } eng_state_t;

  eng_state_t               state;
  logic                     finish;
  logic                     fall;
  logic                     pend;
  logic                     head_pend;
  logic [CW-1:0]            n;
  logic [CW-1:0]            o;
  logic [CW-1:0]            j;
  logic [CW-1:0]            acc;
  logic [CW-1:0]            rise_o;
  logic signed [SAMPLE_W-1:0] vo;

  logic [CW-1:0] jend;
  logic          issue;
  logic [CW-1:0] len_j;
  logic [CW-1:0] cand;
  logic          hit;
  logic [CW:0]   sum;

  assign jend      = fall ? n : o;
  assign issue     = (state == ST_SCAN) && (j != jend);
  assign rd_addr   = (state == ST_HEAD) ? o[AW-1:0] : j[AW-1:0];
  assign len_j     = fall ? len_rdata[CW-1:0] : len_rdata[2*CW-1:CW];
  assign cand      = len_j + 1'b1;
  assign hit       = pend && ($signed(val_rdata) < vo) && (cand > acc);
  assign sum       = {1'b0, rise_o} + {1'b0, acc} - 1'b1;
  assign len_we    = (state == ST_WRITE);
  assign len_waddr = o[AW-1:0];
  assign len_wdata = fall ? {rise_o, acc} : {acc, {CW{1'b0}}};
  assign stat.busy   = (state != ST_IDLE);
  assign stat.finish = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finish    <= 1'b0;
      pend      <= 1'b0;
      head_pend <= 1'b0;
    end else begin
      finish <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (go) begin
            n     <= n_in;
            o     <= '0;
            fall  <= 1'b0;
            best  <= '0;
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          head_pend <= 1'b1;
          pend      <= 1'b0;
          acc       <= CW'(1);
          j         <= fall ? o + 1'b1 : '0;
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          pend      <= issue;
          head_pend <= 1'b0;
          if (issue) begin
            j <= j + 1'b1;
          end
          if (head_pend) begin
            vo     <= $signed(val_rdata);
            rise_o <= len_rdata[2*CW-1:CW];
          end
          if (hit) begin
            acc <= cand;
          end
          if (!issue && !pend && !head_pend) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_HEAD;
          if (fall) begin
            if (sum > best) begin
              best <= sum;
            end
            if (o == '0) begin
              finish <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              o <= o - 1'b1;
            end
          end else if (o == n - 1'b1) begin
            fall <= 1'b1;
          end else begin
            o <= o + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_outer_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (o < n))
    else $error("outer index beyond sequence length");
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (acc >= CW'(1) && acc <= n))
    else $error("run length out of range");
  a_finish_pulse: assert property (@(posedge clk) disable iff (rst)
    finish |=> !finish)
    else $error("finish held for more than one cycle");
  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    finish |-> (best <= {1'b0, n} && best != '0))
    else $error("bitonic length outside one to sequence length");
`endif

endmodule

@@ design/longest_bitonic_subsequence_core.sv @@
// Top level of the longest bitonic subsequence core.
// Loads samples into the value RAM, runs lbs_engine on the stored sequence.
// Depends on lbs_pkg, lbs_ram and lbs_engine.
//
// Usage: a sample transfer is taken at a rising edge with start high and busy
// low. Samples load one per cycle while busy is low. Up to MAX_LEN samples are
// stored; later samples of the same sequence are dropped and the overflow flag
// is set. When the sample with last_item set is taken, busy rises on the next
// cycle and the engine computes rising run lengths forward and falling run
// lengths backward through the value and length RAMs, one stored element per
// cycle in each inner stream. Each outer step costs a head read, the inner
// stream, a pipeline drain and a write-back. In the cycle after busy falls,
// done is high for exactly one cycle with the result; the receiver cannot stall
// and must take it then. A new sequence may be loaded from the cycle busy falls.
// Reset clears the element count, the overflow flag and the sequencer; RAM
// contents need no clearing because only entries written for the current
// sequence are used.
module longest_bitonic_subsequence_core #(
  parameter int MAX_LEN = lbs_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lbs_pkg::item_t   item,
  output logic             done,
  output lbs_pkg::result_t result
);
  import lbs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  logic [CW-1:0] count;
  logic          ovf;

  logic          accept;
  logic          full;
  logic          go;
  logic [CW-1:0] n_in;

  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] val_rdata;
  logic [2*CW-1:0]     len_rdata;
  logic                len_we;
  logic [AW-1:0]       len_waddr;
  logic [2*CW-1:0]     len_wdata;
  logic [CW:0]         best;
  lbs_stat_t           stat;

  assign busy   = stat.busy;
  assign accept = start && !busy;
  assign full   = (count == FULL);
  assign go     = accept && item.last_item;
  assign n_in   = full ? count : count + 1'b1;

  lbs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_LEN)
  ) u_value_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (count[AW-1:0]),
    .wdata (item.sample_value),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  lbs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_LEN)
  ) u_length_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (rd_addr),
    .rdata (len_rdata)
  );

  lbs_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .n_in      (n_in),
    .rd_addr   (rd_addr),
    .val_rdata (val_rdata),
    .len_rdata (len_rdata),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .best      (best),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= stat.finish;
      if (stat.finish) begin
        ovf <= 1'b0;
      end
      if (accept) begin
        if (full) begin
          ovf <= 1'b1;
        end
        if (item.last_item) begin
          count <= '0;
        end else if (!full) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.finish) begin
      result.bitonic_length <= LENGTH_W'(best);
      result.overflow       <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("element count beyond store size");
  a_count_clear_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count == '0))
    else $error("element count not cleared while computing");
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stat.finish))
    else $error("result transfer without engine finish");
`endif

endmodule
